// ===== rtl/mat_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat_pkg: shared definitions for the masked address table
// Operation and status codes and the fixed field widths of the request and
// response channels.
// ---------------------------------------------------------------------------
package mat_pkg;

	// field widths
	localparam int ACT_W    = 2;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 3;
	localparam int FILL_W   = 7;

	// operation codes
	localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FILTER = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MATCH     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd5;

endpackage

// ===== rtl/mat_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat_req_if: request channel of the masked address table
// Valid/ready handshake carrying an operation, an address and a mask.
// ---------------------------------------------------------------------------
interface mat_req_if;
	logic                         valid;
	logic                         ready;
	logic [mat_pkg::ACT_W-1:0]    action;
	logic [mat_pkg::ADDR_W-1:0]   address;
	logic [mat_pkg::ADDR_W-1:0]   search_mask;

	modport source (output valid, output action, output address, output search_mask,
		input ready);
	modport sink (input valid, input action, input address, input search_mask,
		output ready);
endinterface

// ===== rtl/mat_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat_rsp_if: response channel of the masked address table
// Valid/ready handshake carrying a status, an entry, a last flag and fill.
// ---------------------------------------------------------------------------
interface mat_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mat_pkg::STATUS_W-1:0]   status;
	logic [mat_pkg::ADDR_W-1:0]     entry;
	logic                           last;
	logic [mat_pkg::FILL_W-1:0]     fill_after;

	modport source (output valid, output status, output entry, output last,
		output fill_after, input ready);
	modport sink (input valid, input status, input entry, input last,
		input fill_after, output ready);
endinterface

// ===== rtl/masked_address_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// masked_address_table: ordered table of IPv4 addresses
// Add appends, remove deletes the first exact match and closes the gap,
// filter returns every entry matching the query under a mask, in order.
// ---------------------------------------------------------------------------
// Scan: remove and filter read one stored entry per cycle through the RAM
// read port and the shared compare unit while the scan is not stalled.
// One request at a time; a filter stalls its scan while the output is held.
// Reset: arst_n clears the table count and all control; RAM is not cleared.
// ---------------------------------------------------------------------------
module masked_address_table #(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	mat_req_if.sink  req,
	mat_rsp_if.source rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	// control state
	state_t                          state_q;
	logic   [CW-1:0]                 fill_q;
	logic   [AW-1:0]                 ptr_q;
	logic                            found_q;
	logic                            held_q;
	logic                            out_v_q;

	// payload state
	logic   [mat_pkg::ACT_W-1:0]     op_q;
	logic   [mat_pkg::ADDR_W-1:0]    key_q;
	logic   [mat_pkg::ADDR_W-1:0]    mask_q;
	logic   [mat_pkg::ADDR_W-1:0]    held_entry_q;
	logic   [mat_pkg::STATUS_W-1:0]  fin_status_q;
	logic   [mat_pkg::ADDR_W-1:0]    fin_entry_q;
	logic   [mat_pkg::STATUS_W-1:0]  out_status_q;
	logic   [mat_pkg::ADDR_W-1:0]    out_entry_q;
	logic                            out_last_q;
	logic   [CW-1:0]                 out_fill_q;

	// datapath signals
	logic                            req_fire;
	logic                            slot_free;
	logic                            scan;
	logic                            is_filter;
	logic                            match;
	logic                            last_ent;
	logic                            stall;
	logic                            advance;
	logic                            emit_mid;
	logic                            emit_fin;
	logic                            ram_we;
	logic   [AW-1:0]                 ram_waddr;
	logic   [mat_pkg::ADDR_W-1:0]    ram_wdata;
	logic   [AW-1:0]                 ram_raddr;
	logic   [mat_pkg::ADDR_W-1:0]    ram_rdata;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign slot_free = !out_v_q || rsp.ready;

	// entry store
	mat_ram #(
		.WIDTH (mat_pkg::ADDR_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared masked compare
	mat_cmp u_cmp (
		.stored (ram_rdata),
		.key    (key_q),
		.mask   (mask_q),
		.eq     (match)
	);

	// scan control: during a scan, read data holds the entry at ptr_q
	assign scan      = (state_q == S_SCAN);
	assign is_filter = (op_q == mat_pkg::ACT_FILTER);
	assign last_ent  = (CW'(ptr_q) == (fill_q - CW'(1)));
	assign stall     = scan && is_filter && match && held_q && !slot_free;
	assign advance   = scan && !stall;
	assign emit_mid  = scan && is_filter && match && held_q && slot_free;
	assign emit_fin  = (state_q == S_FINISH) && slot_free;

	// read address follows the next pointer; RAM write for add or shift down
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q - AW'(1);
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q;
		if (req_fire) begin
			ram_raddr = '0;
			if (req.action == mat_pkg::ACT_ADD && fill_q < CW'(DEPTH)) begin
				ram_we    = 1'b1;
				ram_waddr = fill_q[AW-1:0];
				ram_wdata = req.address;
			end
		end else if (advance) begin
			ram_raddr = ptr_q + AW'(1);
			if (!is_filter && found_q) begin
				ram_we = 1'b1;
			end
		end
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			ptr_q   <= '0;
			found_q <= 1'b0;
			held_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit_mid || emit_fin) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						ptr_q   <= '0;
						found_q <= 1'b0;
						held_q  <= 1'b0;
						unique case (req.action)
							mat_pkg::ACT_ADD: begin
								if (fill_q < CW'(DEPTH)) begin
									fill_q <= fill_q + CW'(1);
								end
								state_q <= S_FINISH;
							end
							mat_pkg::ACT_REMOVE, mat_pkg::ACT_FILTER: begin
								state_q <= (fill_q == '0) ? S_FINISH : S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (advance) begin
						if (is_filter) begin
							if (match) begin
								held_q <= 1'b1;
							end
						end else if (match) begin
							found_q <= 1'b1;
						end
						if (last_ent) begin
							if (!is_filter && (found_q || match)) begin
								fill_q <= fill_q - CW'(1);
							end
							state_q <= S_FINISH;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, held match and final result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q        <= req.action;
			key_q       <= req.address;
			mask_q      <= (req.action == mat_pkg::ACT_REMOVE) ? '1 : req.search_mask;
			fin_entry_q <= '0;
			unique case (req.action)
				mat_pkg::ACT_ADD: begin
					fin_status_q <= (fill_q < CW'(DEPTH)) ? mat_pkg::ST_ADDED
						: mat_pkg::ST_FULL;
				end
				mat_pkg::ACT_REMOVE: fin_status_q <= mat_pkg::ST_NOT_FOUND;
				default:             fin_status_q <= mat_pkg::ST_NO_MATCH;
			endcase
		end
		if (advance) begin
			if (is_filter && match) begin
				held_entry_q <= ram_rdata;
			end
			if (last_ent) begin
				if (is_filter) begin
					if (match) begin
						fin_status_q <= mat_pkg::ST_MATCH;
						fin_entry_q  <= ram_rdata;
					end else if (held_q) begin
						fin_status_q <= mat_pkg::ST_MATCH;
						fin_entry_q  <= held_entry_q;
					end
				end else if (found_q || match) begin
					fin_status_q <= mat_pkg::ST_REMOVED;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit_mid) begin
			out_status_q <= mat_pkg::ST_MATCH;
			out_entry_q  <= held_entry_q;
			out_last_q   <= 1'b0;
			out_fill_q   <= fill_q;
		end else if (emit_fin) begin
			out_status_q <= fin_status_q;
			out_entry_q  <= fin_entry_q;
			out_last_q   <= 1'b1;
			out_fill_q   <= fill_q;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_status_q;
	assign rsp.entry      = out_entry_q;
	assign rsp.last       = out_last_q;
	assign rsp.fill_after = mat_pkg::FILL_W'(out_fill_q);

`ifndef SYNTH
	// the table never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	// the scan pointer stays inside the stored entries
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan |-> (CW'(ptr_q) < fill_q))
		else $error("scan pointer beyond fill");

	// a stalled filter scan keeps its place and its held match
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (scan && $stable(ptr_q) && held_q))
		else $error("filter scan moved while stalled");

	// RAM is written only by an accepted add or during a remove scan
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((req_fire && req.action == mat_pkg::ACT_ADD)
			|| (scan && op_q == mat_pkg::ACT_REMOVE && found_q)))
		else $error("unexpected table write");

	// a remove never flags a held filter match
	a_held_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(scan && held_q) |-> is_filter)
		else $error("held match outside a filter");
`endif

endmodule

// ===== rtl/mat_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module mat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mat_cmp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat_cmp: masked equality compare
// Shared unit comparing a stored entry with the key under a mask; the
// remove scan uses an all-ones mask, the filter scan the request's mask.
// ---------------------------------------------------------------------------
module mat_cmp (
	input  logic [mat_pkg::ADDR_W-1:0] stored,
	input  logic [mat_pkg::ADDR_W-1:0] key,
	input  logic [mat_pkg::ADDR_W-1:0] mask,
	output logic                       eq
);

	// bits outside the mask are ignored
	assign eq = ((stored ^ key) & mask) == '0;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the masked address table
// Requests are queued up front, driven with random gaps and checked against
// an in-bench table model. Covers adds up to and past a full table, removes
// that hit, miss and pick the first of duplicates, and filters under zero,
// full, prefix and random masks, under random backpressure outside quiet stretches.
// ---------------------------------------------------------------------------
module testbench;

	localparam int TABLE_DEPTH = 64;
	localparam int RANDOM_TAIL = 20;
	localparam int DRAIN_CYCLES = 80;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic [mat_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [mat_pkg::ACT_W-1:0]  action;
		logic [mat_pkg::ADDR_W-1:0] address;
		logic [mat_pkg::ADDR_W-1:0] search_mask;
	} table_req_t;

	typedef struct packed {
		logic [mat_pkg::STATUS_W-1:0] status;
		logic [mat_pkg::ADDR_W-1:0]   entry;
		logic                         last;
		logic [mat_pkg::FILL_W-1:0]   fill_after;
	} table_rsp_t;

	logic clk;
	logic arst_n;

	mat_req_if req ();
	mat_rsp_if rsp ();

	masked_address_table #(.DEPTH(TABLE_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// requests waiting to be driven, and results still owed by the block
	table_req_t pending_requests[$];
	table_rsp_t owed_results[$];

	// table model used for prediction
	logic [mat_pkg::ADDR_W-1:0] model_entries[TABLE_DEPTH];
	int                         model_fill = 0;

	// mirror of the table used only to steer stimulus
	logic [mat_pkg::ADDR_W-1:0] steer_entries[$];
	logic [15:0]                subnet_pool[4];

	longint     cycle_count = 0;
	int         error_count = 0;
	int         requests_by_action[4] = '{default: 0};
	int         results_checked = 0;
	int         full_rejects = 0;
	int         peak_fill = 0;
	int         gap_left;
	int         stall_left;
	int         delay_pick;
	table_rsp_t front_result;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench: errors");
			$finish;
		end
	end

	// random idle length: mostly short, a few long, none in quiet stretches
	function automatic int pick_delay();
		int roll;
		if ((cycle_count % 1200) < 300)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// work out the results owed for one accepted request
	task automatic predict_table_op(input table_req_t r);
		int hit;
		int final_hit;
		logic [mat_pkg::ADDR_W-1:0] key;
		requests_by_action[r.action]++;
		case (r.action)
			mat_pkg::ACT_ADD: begin
				if (model_fill >= TABLE_DEPTH) begin
					full_rejects++;
					owed_results.push_back({mat_pkg::ST_FULL, {mat_pkg::ADDR_W{1'b0}},
						1'b1, mat_pkg::FILL_W'(model_fill)});
				end else begin
					model_entries[model_fill] = r.address;
					model_fill++;
					owed_results.push_back({mat_pkg::ST_ADDED, {mat_pkg::ADDR_W{1'b0}},
						1'b1, mat_pkg::FILL_W'(model_fill)});
				end
			end
			mat_pkg::ACT_REMOVE: begin
				hit = -1;
				for (int i = 0; i < model_fill; i++)
					if (hit < 0 && model_entries[i] == r.address)
						hit = i;
				if (hit >= 0) begin
					for (int i = hit; i < model_fill - 1; i++)
						model_entries[i] = model_entries[i + 1];
					model_fill--;
					owed_results.push_back({mat_pkg::ST_REMOVED, {mat_pkg::ADDR_W{1'b0}},
						1'b1, mat_pkg::FILL_W'(model_fill)});
				end else begin
					owed_results.push_back({mat_pkg::ST_NOT_FOUND,
						{mat_pkg::ADDR_W{1'b0}}, 1'b1, mat_pkg::FILL_W'(model_fill)});
				end
			end
			mat_pkg::ACT_FILTER: begin
				key = r.address & r.search_mask;
				final_hit = -1;
				for (int i = 0; i < model_fill; i++)
					if ((model_entries[i] & r.search_mask) == key)
						final_hit = i;
				if (final_hit < 0) begin
					owed_results.push_back({mat_pkg::ST_NO_MATCH, {mat_pkg::ADDR_W{1'b0}},
						1'b1, mat_pkg::FILL_W'(model_fill)});
				end else begin
					for (int i = 0; i <= final_hit; i++)
						if ((model_entries[i] & r.search_mask) == key)
							owed_results.push_back({mat_pkg::ST_MATCH, model_entries[i],
								i == final_hit, mat_pkg::FILL_W'(model_fill)});
				end
			end
			default: ;
		endcase
		if (model_fill > peak_fill)
			peak_fill = model_fill;
	endtask

	// queue one request and keep the steering mirror in step
	task automatic queue_request(input logic [mat_pkg::ACT_W-1:0] action,
		input logic [mat_pkg::ADDR_W-1:0] address,
		input logic [mat_pkg::ADDR_W-1:0] search_mask);
		int hit;
		pending_requests.push_back({action, address, search_mask});
		if (action == mat_pkg::ACT_ADD && steer_entries.size() < TABLE_DEPTH)
			steer_entries.push_back(address);
		if (action == mat_pkg::ACT_REMOVE) begin
			hit = -1;
			foreach (steer_entries[i])
				if (hit < 0 && steer_entries[i] == address)
					hit = i;
			if (hit >= 0)
				steer_entries.delete(hit);
		end
	endtask

	function automatic logic [mat_pkg::ADDR_W-1:0] pick_address();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return {subnet_pool[$urandom_range(0, 3)], 16'($urandom)};
		if (roll < 7 && steer_entries.size() > 0)
			return steer_entries[$urandom_range(0, steer_entries.size() - 1)];
		if (roll == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'h0000_0001;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [mat_pkg::ADDR_W-1:0] pick_mask();
		int prefix;
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom;
			default: begin
				prefix = $urandom_range(0, 32);
				if (prefix == 0)
					return 32'h0000_0000;
				return 32'hFFFF_FFFF << (32 - prefix);
			end
		endcase
	endfunction

	// one random request, adds weighted by add_percent
	task automatic queue_random(input int add_percent);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < add_percent)
			queue_request(mat_pkg::ACT_ADD, pick_address(), $urandom);
		else if (roll < add_percent + (100 - add_percent) / 2)
			queue_request(mat_pkg::ACT_REMOVE,
				($urandom_range(0, 3) != 0 && steer_entries.size() > 0) ?
				steer_entries[$urandom_range(0, steer_entries.size() - 1)] :
				pick_address(), $urandom);
		else if (roll < 97)
			queue_request(mat_pkg::ACT_FILTER, pick_address(), pick_mask());
		else
			queue_request(ACT_UNUSED, $urandom, $urandom);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.action      <= mat_pkg::ACT_ADD;
			req.address     <= '0;
			req.search_mask <= '0;
			gap_left        <= 0;
		end else begin
			if (req.valid && req.ready)
				predict_table_op({req.action, req.address, req.search_mask});
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					{req.action, req.address, req.search_mask} <=
						pending_requests.pop_front();
					req.valid <= 1'b1;
					gap_left  <= pick_delay();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_checked++;
				if (owed_results.size() == 0) begin
					$error("unexpected result: status %0d entry %h last %0d fill %0d",
						rsp.status, rsp.entry, rsp.last, rsp.fill_after);
					error_count++;
				end else begin
					front_result = owed_results.pop_front();
					if (rsp.status !== front_result.status) begin
						$error("status: expected %0d, actual %0d",
							front_result.status, rsp.status);
						error_count++;
					end
					if (rsp.entry !== front_result.entry) begin
						$error("entry: expected %h, actual %h",
							front_result.entry, rsp.entry);
						error_count++;
					end
					if (rsp.last !== front_result.last) begin
						$error("last: expected %0d, actual %0d",
							front_result.last, rsp.last);
						error_count++;
					end
					if (rsp.fill_after !== front_result.fill_after) begin
						$error("fill_after: expected %0d, actual %0d",
							front_result.fill_after, rsp.fill_after);
						error_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp.ready  <= 1'b0;
			end else begin
				delay_pick = pick_delay();
				rsp.ready  <= (delay_pick == 0);
				stall_left <= (delay_pick == 0) ? 0 : delay_pick - 1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		arst_n = 1'b0;
		foreach (subnet_pool[i])
			subnet_pool[i] = 16'($urandom);
		subnet_pool[0] = 16'hC0A8;

		// directed: empty table, unused code, duplicates, mask extremes
		queue_request(mat_pkg::ACT_FILTER, 32'h0A00_0001, 32'hFFFF_FF00);
		queue_request(mat_pkg::ACT_REMOVE, 32'h0A00_0001, 32'h0000_0000);
		queue_request(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(mat_pkg::ACT_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_request(mat_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_request(mat_pkg::ACT_ADD, 32'hC0A8_0101, 32'h0000_0000);
		queue_request(mat_pkg::ACT_ADD, 32'hC0A8_0102, 32'h0000_0000);
		queue_request(mat_pkg::ACT_ADD, 32'hC0A8_0101, 32'h0000_0000);
		queue_request(mat_pkg::ACT_ADD, 32'h0A00_0001, 32'h0000_0000);
		queue_request(mat_pkg::ACT_FILTER, 32'hC0A8_0000, 32'hFFFF_0000);
		queue_request(mat_pkg::ACT_FILTER, 32'h1234_5678, 32'h0000_0000);
		queue_request(mat_pkg::ACT_FILTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(mat_pkg::ACT_FILTER, 32'h1234_5678, 32'hFFFF_FFFF);
		queue_request(mat_pkg::ACT_REMOVE, 32'hC0A8_0101, 32'hFFFF_FFFF);
		queue_request(mat_pkg::ACT_FILTER, 32'hC0A8_0101, 32'hFFFF_FFFF);
		queue_request(mat_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
		queue_request(mat_pkg::ACT_REMOVE, 32'h0A00_0001, 32'h0000_0000);
		queue_request(mat_pkg::ACT_REMOVE, 32'hDEAD_BEEF, 32'h0000_0000);
		queue_request(ACT_UNUSED, 32'h0000_0000, 32'h0000_0000);
		queue_request(mat_pkg::ACT_FILTER, 32'h0000_0000, 32'hAAAA_AAAA);

		// random: fill the table, push past full, then churn
		while (steer_entries.size() < TABLE_DEPTH)
			queue_random(80);
		repeat (3)
			queue_request(mat_pkg::ACT_ADD, pick_address(), $urandom);
		queue_request(mat_pkg::ACT_FILTER, $urandom, 32'h0000_0000);
		queue_request(mat_pkg::ACT_FILTER, {subnet_pool[0], 16'h0}, 32'hFFFF_0000);
		repeat (RANDOM_TAIL)
			queue_random(25);

		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() > 0 || req.valid || owed_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d adds, %0d removes, %0d filters, %0d unused codes",
			requests_by_action[mat_pkg::ACT_ADD], requests_by_action[mat_pkg::ACT_REMOVE],
			requests_by_action[mat_pkg::ACT_FILTER], requests_by_action[ACT_UNUSED]);
		$display("checked %0d results, peak fill %0d, %0d adds rejected as full",
			results_checked, peak_fill, full_rejects);
		if (error_count == 0 && owed_results.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mat_pkg.sv
rtl/mat_req_if.sv
rtl/mat_rsp_if.sv
rtl/mat_ram.sv
rtl/mat_cmp.sv
rtl/masked_address_table.sv
sim/testbench.sv
